### hdl/hkx_pkg.sv
// ----------------------------------------------------------------------------
// Keyed stream cipher package
// Types, constants and lookup functions shared by the controller, the
// datapath and the checker.
// ----------------------------------------------------------------------------
package hkx_pkg;

    // Item opcodes.
    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_DATA = 2'd1,
        OP_HDR  = 2'd2,
        OP_NONE = 2'd3
    } opcode_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SEED    = 3'd0;
    localparam logic [2:0] CFG_SALT_A1 = 3'd1;
    localparam logic [2:0] CFG_SALT_A2 = 3'd2;
    localparam logic [2:0] CFG_SALT_A3 = 3'd3;
    localparam logic [2:0] CFG_SALT_B0 = 3'd4;
    localparam logic [2:0] CFG_SALT_B1 = 3'd5;
    localparam logic [2:0] CFG_SALT_B2 = 3'd6;
    localparam logic [2:0] CFG_SALT_B3 = 3'd7;
    localparam int         CFG_COUNT   = 8;

    // MurmurHash3 x64_128 constants.
    localparam logic [63:0] MM_C1   = 64'h87c37b91114253d5;
    localparam logic [63:0] MM_C2   = 64'h4cf5ad432745937f;
    localparam logic [63:0] FM_C1   = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FM_C2   = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] MM_ADD1 = 64'h0000000052dce729;
    localparam logic [63:0] MM_ADD2 = 64'h0000000038495ab5;
    localparam logic [63:0] MM_LEN  = 64'h0000000000000010;

    // MD5 constants.
    localparam logic [31:0] MD5_A0       = 32'h67452301;
    localparam logic [31:0] MD5_B0       = 32'hefcdab89;
    localparam logic [31:0] MD5_C0       = 32'h98badcfe;
    localparam logic [31:0] MD5_D0       = 32'h10325476;
    localparam logic [31:0] MD5_PAD      = 32'h00000080;
    localparam logic [31:0] MD5_LEN_BITS = 32'd128;
    localparam logic [3:0]  MD5_PAD_IDX  = 4'd4;
    localparam logic [3:0]  MD5_LEN_IDX  = 4'd14;
    localparam logic [5:0]  MD5_LAST_RND = 6'd63;

    // Micro-operations issued by the controller to the datapath.
    typedef enum logic [4:0] {
        UOP_IDLE,
        UOP_DATA,
        UOP_INIT,
        UOP_H1A,
        UOP_H1B,
        UOP_H2A,
        UOP_H2B,
        UOP_FINA,
        UOP_FINB,
        UOP_F1W,
        UOP_F2W,
        UOP_ENDA,
        UOP_ENDB,
        UOP_HOUT,
        UOP_MINIT,
        UOP_MP1,
        UOP_MP2,
        UOP_MFIN
    } uop_t;

    // Operand pairs for the shared multiplier.
    typedef enum logic [2:0] {
        MS_LO_C1,
        MS_K31_C2,
        MS_HI_C2,
        MS_K33_C1,
        MS_H1_F1,
        MS_H2_F1,
        MS_K_F2
    } mul_sel_t;

    // Controller states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_K1A,
        S_K1B,
        S_H1A,
        S_H1B,
        S_K2A,
        S_K2B,
        S_H2A,
        S_H2B,
        S_FINA,
        S_FINB,
        S_F1A,
        S_F1B,
        S_F1W,
        S_F2A,
        S_F2B,
        S_F2W,
        S_ENDA,
        S_ENDB,
        S_HOUT,
        S_MINIT,
        S_MP1,
        S_MP2,
        S_MFIN
    } state_t;

    typedef struct packed {
        uop_t       uop;
        logic       mul_start;
        mul_sel_t   mul_sel;
        logic [5:0] rnd;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
    } status_t;

    // MD5 additive constants.
    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    // MD5 rotate amounts, indexed by round group and step within four.
    function automatic logic [4:0] md5_s(input logic [5:0] i);
        logic [4:0] s;
        unique case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
        endcase
        return s;
    endfunction

    // MD5 message word index for a round.
    function automatic logic [3:0] md5_g(input logic [5:0] i);
        logic [3:0] g;
        unique case (i[5:4])
            2'd0:    g = i[3:0];
            2'd1:    g = 4'(i[3:0] * 4'd5 + 4'd1);
            2'd2:    g = 4'(i[3:0] * 4'd3 + 4'd5);
            default: g = 4'(i[3:0] * 4'd7);
        endcase
        return g;
    endfunction

endpackage

### hdl/hkx_mul64.sv
// ----------------------------------------------------------------------------
// 64-bit modular multiplier
// Forms the low 64 bits of a 64 x 64 product with one 32 x 32 multiplier used
// in turn over the partial products; done pulses in the cycle after the last one.
// ----------------------------------------------------------------------------
module hkx_mul64
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] p
);

    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic        busy_reg;
    logic        busy_next;
    logic [1:0]  step_reg;
    logic [1:0]  step_next;
    logic        done_reg;
    logic        done_next;
    logic [31:0] mx;
    logic [31:0] my;
    logic [63:0] pp;

    // Partial product selection: low x low, low x high, high x low.
    always_comb
    begin
        case (step_reg)
            2'd0:    begin mx = a_reg[31:0];  my = b_reg[31:0];  end
            2'd1:    begin mx = a_reg[31:0];  my = b_reg[63:32]; end
            default: begin mx = a_reg[63:32]; my = b_reg[31:0];  end
        endcase
        pp = mx * my;
    end

    // Accumulation and sequencing.
    always_comb
    begin
        acc_next  = acc_reg;
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 2'd0;
        end
        else if (busy_reg)
        begin
            if (step_reg == 2'd0)
            begin
                acc_next = pp;
            end
            else
            begin
                acc_next = {acc_reg[63:32] + pp[31:0], acc_reg[31:0]};
            end
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd2)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

### hdl/hkx_ctrl.sv
// ----------------------------------------------------------------------------
// Cipher controller
// Sequences the hash steps, the shared multiplier and the MD5 rounds, and
// owns the input and output handshakes.
// ----------------------------------------------------------------------------
module hkx_ctrl
    import hkx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] opcode,
    output logic       out_valid,
    input  logic       out_ready,
    output cmd_t       cmd,
    input  status_t    status
);

    state_t     state_reg;
    state_t     state_next;
    logic       wait_reg;
    logic       wait_next;
    logic       hdr_reg;
    logic       hdr_next;
    logic [5:0] rnd_reg;
    logic [5:0] rnd_next;
    logic       outv_reg;
    logic       outv_next;
    logic       is_mul;
    mul_sel_t   msel;
    state_t     mul_after;
    logic       slot_free;

    assign slot_free = !outv_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wait_reg  <= 1'b0;
            hdr_reg   <= 1'b0;
            rnd_reg   <= 6'd0;
            outv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            hdr_reg   <= hdr_next;
            rnd_reg   <= rnd_next;
            outv_reg  <= outv_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        wait_next     = wait_reg;
        hdr_next      = hdr_reg;
        rnd_next      = rnd_reg;
        outv_next     = outv_reg && !out_ready;
        in_ready      = 1'b0;
        is_mul        = 1'b0;
        msel          = MS_LO_C1;
        mul_after     = S_IDLE;
        cmd.uop       = UOP_IDLE;
        cmd.mul_start = 1'b0;
        cmd.mul_sel   = MS_LO_C1;
        cmd.rnd       = rnd_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = slot_free;
                if (in_valid && slot_free)
                begin
                    case (opcode_t'(opcode))
                        OP_DATA:
                        begin
                            cmd.uop   = UOP_DATA;
                            outv_next = 1'b1;
                        end
                        OP_LOAD, OP_HDR:
                        begin
                            cmd.uop    = UOP_INIT;
                            hdr_next   = (opcode_t'(opcode) == OP_HDR);
                            state_next = S_K1A;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_K1A:  begin is_mul = 1'b1; msel = MS_LO_C1;  mul_after = S_K1B; end
            S_K1B:  begin is_mul = 1'b1; msel = MS_K31_C2; mul_after = S_H1A; end
            S_H1A:  begin cmd.uop = UOP_H1A; state_next = S_H1B; end
            S_H1B:  begin cmd.uop = UOP_H1B; state_next = S_K2A; end
            S_K2A:  begin is_mul = 1'b1; msel = MS_HI_C2;  mul_after = S_K2B; end
            S_K2B:  begin is_mul = 1'b1; msel = MS_K33_C1; mul_after = S_H2A; end
            S_H2A:  begin cmd.uop = UOP_H2A; state_next = S_H2B; end
            S_H2B:  begin cmd.uop = UOP_H2B; state_next = S_FINA; end
            S_FINA: begin cmd.uop = UOP_FINA; state_next = S_FINB; end
            S_FINB: begin cmd.uop = UOP_FINB; state_next = S_F1A; end
            S_F1A:  begin is_mul = 1'b1; msel = MS_H1_F1; mul_after = S_F1B; end
            S_F1B:  begin is_mul = 1'b1; msel = MS_K_F2;  mul_after = S_F1W; end
            S_F1W:  begin cmd.uop = UOP_F1W; state_next = S_F2A; end
            S_F2A:  begin is_mul = 1'b1; msel = MS_H2_F1; mul_after = S_F2B; end
            S_F2B:  begin is_mul = 1'b1; msel = MS_K_F2;  mul_after = S_F2W; end
            S_F2W:  begin cmd.uop = UOP_F2W; state_next = S_ENDA; end
            S_ENDA: begin cmd.uop = UOP_ENDA; state_next = S_ENDB; end
            S_ENDB:
            begin
                cmd.uop    = UOP_ENDB;
                state_next = hdr_reg ? S_HOUT : S_MINIT;
            end
            S_HOUT:
            begin
                // Wait for the output register to free up.
                if (slot_free)
                begin
                    cmd.uop    = UOP_HOUT;
                    outv_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MINIT:
            begin
                cmd.uop    = UOP_MINIT;
                rnd_next   = 6'd0;
                state_next = S_MP1;
            end
            S_MP1:  begin cmd.uop = UOP_MP1; state_next = S_MP2; end
            S_MP2:
            begin
                cmd.uop = UOP_MP2;
                if (rnd_reg == MD5_LAST_RND)
                begin
                    state_next = S_MFIN;
                end
                else
                begin
                    rnd_next   = rnd_reg + 6'd1;
                    state_next = S_MP1;
                end
            end
            S_MFIN: begin cmd.uop = UOP_MFIN; state_next = S_IDLE; end
            default: state_next = S_IDLE;
        endcase

        // Multiplier states: start once, then wait for done.
        if (is_mul)
        begin
            cmd.mul_sel = msel;
            if (!wait_reg)
            begin
                cmd.mul_start = 1'b1;
                wait_next     = 1'b1;
            end
            else if (status.mul_done)
            begin
                wait_next  = 1'b0;
                state_next = mul_after;
            end
        end
    end

    assign out_valid = outv_reg;

endmodule

### hdl/hkx_dp.sv
// ----------------------------------------------------------------------------
// Cipher datapath
// Configuration registers, hash state, MD5 round registers, the stored
// keystream and byte position, and the output register.
// ----------------------------------------------------------------------------
module hkx_dp
    import hkx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic [1:0]  opcode,
    input  logic [31:0] key_word0,
    input  logic [31:0] key_word1,
    input  logic [31:0] key_word2,
    input  logic [31:0] key_word3,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [63:0] block_low,
    input  logic [63:0] block_high,
    input  cmd_t        cmd,
    output status_t     status,
    output logic [7:0]  data_out,
    output logic [63:0] block_low_out,
    output logic [63:0] block_high_out
);

    logic [31:0] cfg_reg [CFG_COUNT];
    logic [31:0] ks_reg [4];
    logic [31:0] ks_next [4];
    logic [3:0]  pos_reg;
    logic [3:0]  pos_next;
    logic [63:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [63:0] blo_reg, blo_next, bhi_reg, bhi_next;
    logic [63:0] h1_reg, h1_next, h2_reg, h2_next;
    logic [31:0] iv_reg [4];
    logic [31:0] iv_next [4];
    logic [31:0] a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic [31:0] t_reg, t_next;
    logic [7:0]  dout_reg, dout_next;
    logic [63:0] olo_reg, olo_next, ohi_reg, ohi_next;
    logic [63:0] mul_a, mul_b, k_val;
    logic        mul_done;
    logic [63:0] h1x, h2x, kx;
    logic [31:0] f_val, m_val, rot_t;
    logic [63:0] rot_w;
    logic [3:0]  g_idx;
    logic [4:0]  s_amt;
    logic        is_load;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_COUNT; i++)
            begin
                cfg_reg[i] <= 32'd0;
            end
        end
        else if (cfg_valid)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // Multiplier operand selection.
    assign kx  = k_val ^ (k_val >> 33);
    assign h1x = h1_reg ^ (h1_reg >> 33);
    assign h2x = h2_reg ^ (h2_reg >> 33);

    always_comb
    begin
        case (cmd.mul_sel)
            MS_LO_C1:  begin mul_a = lo_reg; mul_b = MM_C1; end
            MS_K31_C2: begin mul_a = {k_val[32:0], k_val[63:33]}; mul_b = MM_C2; end
            MS_HI_C2:  begin mul_a = hi_reg; mul_b = MM_C2; end
            MS_K33_C1: begin mul_a = {k_val[30:0], k_val[63:31]}; mul_b = MM_C1; end
            MS_H1_F1:  begin mul_a = h1x; mul_b = FM_C1; end
            MS_H2_F1:  begin mul_a = h2x; mul_b = FM_C1; end
            default:   begin mul_a = kx;  mul_b = FM_C2; end
        endcase
    end

    hkx_mul64 u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (k_val)
    );

    assign status.mul_done = mul_done;

    // MD5 round function, message word and rotation.
    assign g_idx = md5_g(cmd.rnd);
    assign s_amt = md5_s(cmd.rnd);

    always_comb
    begin
        case (cmd.rnd[5:4])
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        if (g_idx < 4'd4)
        begin
            m_val = iv_reg[g_idx[1:0]];
        end
        else if (g_idx == MD5_PAD_IDX)
        begin
            m_val = MD5_PAD;
        end
        else if (g_idx == MD5_LEN_IDX)
        begin
            m_val = MD5_LEN_BITS;
        end
        else
        begin
            m_val = 32'd0;
        end
        rot_w = {t_reg, t_reg} << s_amt;
        rot_t = rot_w[63:32];
    end

    assign is_load = (opcode_t'(opcode) == OP_LOAD);

    // Fixed rotations used by the hash mixing steps.
    function automatic logic [63:0] h1x_rot27(input logic [63:0] x);
        return {x[36:0], x[63:37]};
    endfunction

    function automatic logic [63:0] h2x_rot31(input logic [63:0] x);
        return {x[32:0], x[63:33]};
    endfunction

    // Micro-operation decode.
    always_comb
    begin
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        blo_next  = blo_reg;
        bhi_next  = bhi_reg;
        h1_next   = h1_reg;
        h2_next   = h2_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        d_next    = d_reg;
        t_next    = t_reg;
        dout_next = dout_reg;
        olo_next  = olo_reg;
        ohi_next  = ohi_reg;
        pos_next  = pos_reg;
        for (int i = 0; i < 4; i++)
        begin
            iv_next[i] = iv_reg[i];
            ks_next[i] = ks_reg[i];
        end
        unique case (cmd.uop)
            UOP_IDLE: ;
            UOP_DATA:
            begin
                dout_next = data_byte ^ ks_reg[pos_reg[3:2]][{pos_reg[1:0], 3'b000} +: 8];
                olo_next  = 64'd0;
                ohi_next  = 64'd0;
                pos_next  = last_byte ? 4'd0 : pos_reg + 4'd1;
            end
            UOP_INIT:
            begin
                h1_next  = {32'd0, cfg_reg[CFG_SEED]};
                h2_next  = {32'd0, cfg_reg[CFG_SEED]};
                lo_next  = is_load ? {key_word1, key_word0}
                                   : {cfg_reg[CFG_SALT_A1], key_word0};
                hi_next  = is_load ? {key_word3, key_word2}
                                   : {cfg_reg[CFG_SALT_A3], cfg_reg[CFG_SALT_A2]};
                blo_next = block_low;
                bhi_next = block_high;
            end
            UOP_H1A:
            begin
                h1_next = {h1x_rot27(h1_reg ^ k_val)} + h2_reg;
            end
            UOP_H1B:  h1_next = (h1_reg << 2) + h1_reg + MM_ADD1;
            UOP_H2A:
            begin
                h2_next = {h2x_rot31(h2_reg ^ k_val)} + h1_reg;
            end
            UOP_H2B:  h2_next = (h2_reg << 2) + h2_reg + MM_ADD2;
            UOP_FINA:
            begin
                h1_next = (h1_reg ^ MM_LEN) + (h2_reg ^ MM_LEN);
                h2_next = h2_reg ^ MM_LEN;
            end
            UOP_FINB: h2_next = h2_reg + h1_reg;
            UOP_F1W:  h1_next = kx;
            UOP_F2W:  h2_next = kx;
            UOP_ENDA: h1_next = h1_reg + h2_reg;
            UOP_ENDB: h2_next = h2_reg + h1_reg;
            UOP_HOUT:
            begin
                dout_next = 8'd0;
                olo_next  = blo_reg ^ h1_reg;
                ohi_next  = bhi_reg ^ h2_reg;
            end
            UOP_MINIT:
            begin
                iv_next[0] = h1_reg[31:0]  ^ cfg_reg[CFG_SALT_B0];
                iv_next[1] = h1_reg[63:32] ^ cfg_reg[CFG_SALT_B1];
                iv_next[2] = h2_reg[31:0]  ^ cfg_reg[CFG_SALT_B2];
                iv_next[3] = h2_reg[63:32] ^ cfg_reg[CFG_SALT_B3];
                a_next     = MD5_A0;
                b_next     = MD5_B0;
                c_next     = MD5_C0;
                d_next     = MD5_D0;
            end
            UOP_MP1:  t_next = a_reg + f_val + md5_k(cmd.rnd) + m_val;
            UOP_MP2:
            begin
                a_next = d_reg;
                d_next = c_reg;
                c_next = b_reg;
                b_next = b_reg + rot_t;
            end
            UOP_MFIN:
            begin
                ks_next[0] = MD5_A0 + a_reg;
                ks_next[1] = MD5_B0 + b_reg;
                ks_next[2] = MD5_C0 + c_reg;
                ks_next[3] = MD5_D0 + d_reg;
                pos_next   = 4'd0;
            end
            default: ;
        endcase
    end

    // Keystream and byte position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                ks_reg[i] <= 32'd0;
            end
            pos_reg <= 4'd0;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                ks_reg[i] <= ks_next[i];
            end
            pos_reg <= pos_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        blo_reg  <= blo_next;
        bhi_reg  <= bhi_next;
        h1_reg   <= h1_next;
        h2_reg   <= h2_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        d_reg    <= d_next;
        t_reg    <= t_next;
        dout_reg <= dout_next;
        olo_reg  <= olo_next;
        ohi_reg  <= ohi_next;
        for (int i = 0; i < 4; i++)
        begin
            iv_reg[i] <= iv_next[i];
        end
    end

    assign data_out       = dout_reg;
    assign block_low_out  = olo_reg;
    assign block_high_out = ohi_reg;

endmodule

### hdl/hash_keyed_stream_xor_cipher.sv
// ----------------------------------------------------------------------------
// Keyed stream XOR cipher
// Top level: controller plus datapath with a shared 64-bit multiplier.
// ----------------------------------------------------------------------------
// A data beat's ciphered byte is registered and shown in the cycle after the
// beat is taken, so data streams at one beat per cycle while the output is
// taken. A header beat runs the MurmurHash3 sequence on the shared multiplier
// (eight 64-bit products plus ten mixing steps) and then delivers its result.
// A load-key beat runs the same hash followed by 64 MD5 rounds, each split
// over the MP1 and MP2 states, and gives no result. No beat is accepted while
// a hash or key load is running.
// Configuration writes are taken at any time and should be made while idle.
module hash_keyed_stream_xor_cipher
    import hkx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [31:0] key_word0,
    input  logic [31:0] key_word1,
    input  logic [31:0] key_word2,
    input  logic [31:0] key_word3,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [63:0] block_low,
    input  logic [63:0] block_high,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  data_out,
    output logic [63:0] block_low_out,
    output logic [63:0] block_high_out
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    hkx_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    hkx_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .opcode         (opcode),
        .key_word0      (key_word0),
        .key_word1      (key_word1),
        .key_word2      (key_word2),
        .key_word3      (key_word3),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .block_low      (block_low),
        .block_high     (block_high),
        .cmd            (cmd),
        .status         (status),
        .data_out       (data_out),
        .block_low_out  (block_low_out),
        .block_high_out (block_high_out)
    );

endmodule

### hdl/hkx_checker.sv
// ----------------------------------------------------------------------------
// Cipher port checker
// Watches the top-level ports for handshake and sequencing errors.
// ----------------------------------------------------------------------------
module hkx_checker
    import hkx_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  opcode,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  data_out,
    input logic [63:0] block_low_out,
    input logic [63:0] block_high_out
);

    // A stalled result stays up.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(data_out) && $stable(block_low_out)
                                    && $stable(block_high_out))
        else $error("result payload changed while stalled");

    // An accepted data beat shows its byte in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && opcode == OP_DATA |=> out_valid)
        else $error("data beat gave no result");

    // A key load or header beat closes the input while the hash runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == OP_LOAD || opcode == OP_HDR) |=> !in_ready)
        else $error("input open during hash");

endmodule

bind hash_keyed_stream_xor_cipher hkx_checker u_hkx_checker (.*);

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keyed stream cipher testbench
// Drives load-key, data and header beats through the cipher, including the
// ignored opcode, under random input gaps and output stalls. A behavioral
// model of the hash, digest and byte position predicts every result.
// ----------------------------------------------------------------------------
module tb;
    import hkx_pkg::*;

    typedef struct {
        opcode_t     op;
        logic [31:0] kw0;
        logic [31:0] kw1;
        logic [31:0] kw2;
        logic [31:0] kw3;
        logic [7:0]  byte_in;
        logic        last;
        logic [63:0] blk_lo;
        logic [63:0] blk_hi;
    } beat_t;

    typedef struct {
        logic [7:0]  byte_out;
        logic [63:0] blk_lo;
        logic [63:0] blk_hi;
    } cipher_res_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LOAD_LATENCY   = 250;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [31:0] key_word0;
    logic [31:0] key_word1;
    logic [31:0] key_word2;
    logic [31:0] key_word3;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [63:0] block_low;
    logic [63:0] block_high;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  data_out;
    logic [63:0] block_low_out;
    logic [63:0] block_high_out;

    // Predictor state.
    logic [31:0] regs_mdl [CFG_COUNT];
    logic [7:0]  keystream_mdl [16];
    logic [3:0]  pos_mdl;

    beat_t       pending_beats[$];
    cipher_res_t expected_results[$];
    int          mismatches;
    int          results_seen;
    int          idle_cycles;
    bit          calm;
    bit          timed_out;

    // Pending configuration write.
    logic        cfg_req;
    logic [2:0]  cfg_req_index;
    logic [31:0] cfg_req_data;

    hash_keyed_stream_xor_cipher dut (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] rol64(logic [63:0] x, int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [31:0] rol32(logic [31:0] x, int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [63:0] final_mix(logic [63:0] k);
        k = k ^ (k >> 33);
        k = k * 64'hff51afd7ed558ccd;
        k = k ^ (k >> 33);
        k = k * 64'hc4ceb9fe1a85ec53;
        k = k ^ (k >> 33);
        return k;
    endfunction

    // MurmurHash3 x64_128 of one 16-byte block.
    task automatic murmur_block(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [31:0] seed,
                                output logic [63:0] h1, output logic [63:0] h2);
        logic [63:0] k1;
        logic [63:0] k2;
        h1 = {32'd0, seed};
        h2 = {32'd0, seed};
        k1 = lo * 64'h87c37b91114253d5;
        k1 = rol64(k1, 31) * 64'h4cf5ad432745937f;
        h1 = h1 ^ k1;
        h1 = rol64(h1, 27) + h2;
        h1 = h1 * 64'd5 + 64'h52dce729;
        k2 = hi * 64'h4cf5ad432745937f;
        k2 = rol64(k2, 33) * 64'h87c37b91114253d5;
        h2 = h2 ^ k2;
        h2 = rol64(h2, 31) + h1;
        h2 = h2 * 64'd5 + 64'h38495ab5;
        h1 = h1 ^ 64'd16;
        h2 = h2 ^ 64'd16;
        h1 = h1 + h2;
        h2 = h2 + h1;
        h1 = final_mix(h1);
        h2 = final_mix(h2);
        h1 = h1 + h2;
        h2 = h2 + h1;
    endtask

    // MD5 digest of a 16-byte message, stored into the keystream.
    task automatic digest_to_keystream(input logic [31:0] w [4]);
        logic [31:0] m [16];
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] f;
        logic [31:0] t;
        logic [31:0] fin [4];
        int g;
        a = 32'h67452301;
        b = 32'hefcdab89;
        c = 32'h98badcfe;
        d = 32'h10325476;
        for (int i = 0; i < 16; i++)
        begin
            m[i] = 32'd0;
        end
        for (int i = 0; i < 4; i++)
        begin
            m[i] = w[i];
        end
        m[4] = 32'h80;
        m[14] = 32'd128;
        for (int i = 0; i < 64; i++)
        begin
            case (i / 16)
                0:
                begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1:
                begin
                    f = (b & d) | (c & ~d);
                    g = (5 * i + 1) % 16;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) % 16;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = (7 * i) % 16;
                end
            endcase
            t = d;
            d = c;
            c = b;
            b = b + rol32(a + f + md5_k(6'(i)) + m[g], int'(md5_s(6'(i))));
            a = t;
        end
        fin[0] = 32'h67452301 + a;
        fin[1] = 32'hefcdab89 + b;
        fin[2] = 32'h98badcfe + c;
        fin[3] = 32'h10325476 + d;
        for (int i = 0; i < 16; i++)
        begin
            keystream_mdl[i] = fin[i / 4][8 * (i % 4) +: 8];
        end
    endtask

    // Update the predicted state for one accepted beat and queue its result.
    task automatic predict_cipher(input beat_t bt);
        logic [63:0] h1;
        logic [63:0] h2;
        logic [31:0] w [4];
        cipher_res_t r;
        case (bt.op)
            OP_LOAD:
            begin
                murmur_block({bt.kw1, bt.kw0}, {bt.kw3, bt.kw2}, regs_mdl[CFG_SEED], h1, h2);
                w[0] = h1[31:0] ^ regs_mdl[CFG_SALT_B0];
                w[1] = h1[63:32] ^ regs_mdl[CFG_SALT_B1];
                w[2] = h2[31:0] ^ regs_mdl[CFG_SALT_B2];
                w[3] = h2[63:32] ^ regs_mdl[CFG_SALT_B3];
                digest_to_keystream(w);
                pos_mdl = 4'd0;
            end
            OP_DATA:
            begin
                r.byte_out = bt.byte_in ^ keystream_mdl[pos_mdl];
                r.blk_lo = 64'd0;
                r.blk_hi = 64'd0;
                expected_results.push_back(r);
                pos_mdl = bt.last ? 4'd0 : pos_mdl + 4'd1;
            end
            OP_HDR:
            begin
                murmur_block({regs_mdl[CFG_SALT_A1], bt.kw0},
                             {regs_mdl[CFG_SALT_A3], regs_mdl[CFG_SALT_A2]},
                             regs_mdl[CFG_SEED], h1, h2);
                r.byte_out = 8'd0;
                r.blk_lo = bt.blk_lo ^ h1;
                r.blk_hi = bt.blk_hi ^ h2;
                expected_results.push_back(r);
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic beat_t rand_beat(opcode_t op);
        beat_t bt;
        bt.op = op;
        bt.kw0 = $urandom;
        bt.kw1 = $urandom;
        bt.kw2 = $urandom;
        bt.kw3 = $urandom;
        bt.byte_in = 8'($urandom);
        bt.last = ($urandom_range(0, 15) == 0);
        bt.blk_lo = {$urandom, $urandom};
        bt.blk_hi = {$urandom, $urandom};
        return bt;
    endfunction

    // Input driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            opcode <= OP_NONE;
            key_word0 <= '0;
            key_word1 <= '0;
            key_word2 <= '0;
            key_word3 <= '0;
            data_byte <= '0;
            last_byte <= 1'b0;
            block_low <= '0;
            block_high <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_cipher('{opcode_t'(opcode), key_word0, key_word1, key_word2,
                                 key_word3, data_byte, last_byte, block_low, block_high});
            end
            if ((!in_valid || in_ready) && pending_beats.size() > 0
                && (calm || $urandom_range(0, 99) >= 16))
            begin
                beat_t bt;
                bt = pending_beats.pop_front();
                in_valid <= 1'b1;
                opcode <= bt.op;
                key_word0 <= bt.kw0;
                key_word1 <= bt.kw1;
                key_word2 <= bt.kw2;
                key_word3 <= bt.kw3;
                data_byte <= bt.byte_in;
                last_byte <= bt.last;
                block_low <= bt.blk_lo;
                block_high <= bt.blk_hi;
            end
            else if (in_ready)
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Configuration driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_index <= CFG_SEED;
            cfg_data <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cfg_valid <= 1'b0;
            regs_mdl[cfg_index] = cfg_data;
            cfg_req = 1'b0;
        end
        else if (!cfg_valid && cfg_req)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_req_index;
            cfg_data <= cfg_req_data;
        end
    end

    // Output monitor and stall generator.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                cipher_res_t e;
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result byte=%h lo=%h hi=%h",
                                 data_out, block_low_out, block_high_out);
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (data_out !== e.byte_out || block_low_out !== e.blk_lo
                        || block_high_out !== e.blk_hi)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: got byte=%h lo=%h hi=%h, want byte=%h lo=%h hi=%h",
                                     data_out, block_low_out, block_high_out,
                                     e.byte_out, e.blk_lo, e.blk_hi);
                    end
                end
            end
            out_ready <= calm || ($urandom_range(0, 99) >= 16);
        end
    end

    // Watchdog on accepted beats, results and configuration writes.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (pending_beats.size() > 0 || expected_results.size() > 0 || in_valid
                 || cfg_req)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_req_index = idx;
        cfg_req_data = val;
        cfg_req = 1'b1;
        while (cfg_req)
            @(posedge clk);
    endtask

    // Wait for all beats and results, then let any key load finish.
    task automatic drain();
        while (pending_beats.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (LOAD_LATENCY) @(posedge clk);
    endtask

    task automatic set_all_regs(input int mode);
        for (int i = 0; i < CFG_COUNT; i++)
        begin
            case (mode)
                0: write_reg(3'(i), 32'd0);
                1: write_reg(3'(i), 32'hffffffff);
                default: write_reg(3'(i), $urandom);
            endcase
        end
    endtask

    // Random traffic: mostly keyed data streams with some headers and noise.
    task automatic random_traffic(input int count);
        int sent;
        sent = 0;
        while (sent < count)
        begin
            int pick;
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                pending_beats.push_back(rand_beat(OP_LOAD));
                sent++;
            end
            else if (pick < 18)
            begin
                pending_beats.push_back(rand_beat(OP_HDR));
                sent++;
            end
            else if (pick < 21)
            begin
                pending_beats.push_back(rand_beat(OP_NONE));
            end
            else
            begin
                int n;
                n = $urandom_range(1, 40);
                for (int j = 0; j < n; j++)
                begin
                    beat_t bt;
                    bt = rand_beat(OP_DATA);
                    bt.last = (j == n - 1) && ($urandom_range(0, 1) == 1);
                    pending_beats.push_back(bt);
                end
                sent += n;
            end
        end
    endtask

    initial
    begin
        beat_t bt;
        mismatches = 0;
        results_seen = 0;
        idle_cycles = 0;
        calm = 1'b0;
        timed_out = 1'b0;
        cfg_req = 1'b0;
        pos_mdl = 4'd0;
        for (int i = 0; i < CFG_COUNT; i++)
            regs_mdl[i] = 32'd0;
        for (int i = 0; i < 16; i++)
            keystream_mdl[i] = 8'd0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: data before any key, extremes, last marks, ignored opcode.
        bt = rand_beat(OP_DATA);
        bt.byte_in = 8'h00;
        bt.last = 1'b0;
        pending_beats.push_back(bt);
        bt.byte_in = 8'hff;
        bt.last = 1'b1;
        pending_beats.push_back(bt);
        bt = '{OP_HDR, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0, 1'b0, 64'd0, 64'd0};
        pending_beats.push_back(bt);
        bt = '{OP_HDR, '1, '1, '1, '1, '1, 1'b1, '1, '1};
        pending_beats.push_back(bt);
        bt.op = OP_NONE;
        pending_beats.push_back(bt);
        bt = '{OP_LOAD, '1, '1, '1, '1, '1, 1'b1, '1, '1};
        pending_beats.push_back(bt);
        for (int j = 0; j < 18; j++)
        begin
            bt = rand_beat(OP_DATA);
            bt.byte_in = (j % 2 == 0) ? 8'h00 : 8'hff;
            bt.last = (j == 9);
            pending_beats.push_back(bt);
        end
        drain();

        // Phases over several register settings, extremes first.
        for (int ph = 0; ph < 6; ph++)
        begin
            set_all_regs(ph < 2 ? ph + 0 : 2);
            if (ph == 0)
                set_all_regs(1);
            calm = (ph == 3);
            pending_beats.push_back(rand_beat(OP_LOAD));
            random_traffic(172);
            drain();
        end
        calm = 1'b0;

        $display("Covered key loads, data streams with and without last marks, header");
        $display("blocks and ignored opcodes; %0d results checked.", results_seen);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
